[design/sce_pkg.sv]
// shared types, scan code constants and key tables for the scan code line editor
// no dependencies
package sce_pkg;

    localparam int LINE_MAX = 128;
    localparam logic [7:0] LINE_LAST = 8'(LINE_MAX - 1);

    localparam logic [7:0] SC_BACKSPACE = 8'h0e;
    localparam logic [7:0] SC_ENTER     = 8'h1c;
    localparam logic [7:0] SC_CAPS      = 8'h3a;
    localparam logic [7:0] SC_LSHIFT_D  = 8'h2a;
    localparam logic [7:0] SC_LSHIFT_U  = 8'haa;
    localparam logic [7:0] SC_RSHIFT_D  = 8'h36;
    localparam logic [7:0] SC_RSHIFT_U  = 8'hb6;
    localparam logic [7:0] SC_CTRL_D    = 8'h1d;
    localparam logic [7:0] SC_CTRL_U    = 8'h9d;
    localparam logic [7:0] SC_ALT_D     = 8'h38;
    localparam logic [7:0] SC_ALT_U     = 8'hb8;
    localparam logic [7:0] SC_L         = 8'h26;
    localparam logic [7:0] SC_F1        = 8'h3b;
    localparam logic [7:0] SC_F3        = 8'h3d;

    localparam logic [6:0] CH_SPACE = 7'h20;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_STORE  = 3'd1,
        ACT_ERASE  = 3'd2,
        ACT_DONE   = 3'd3,
        ACT_SWITCH = 3'd4,
        ACT_CLEAR  = 3'd5,
        ACT_READ   = 3'd6
    } action_t;

    typedef enum logic [3:0] {
        OP_NONE    = 4'd0,
        OP_START   = 4'd1,
        OP_CAPS    = 4'd2,
        OP_SHIFT_D = 4'd3,
        OP_SHIFT_U = 4'd4,
        OP_CTRL_D  = 4'd5,
        OP_CTRL_U  = 4'd6,
        OP_ALT_D   = 4'd7,
        OP_ALT_U   = 4'd8,
        OP_ENTER   = 4'd9,
        OP_BKSP    = 4'd10,
        OP_KEY     = 4'd11
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       fkey;
        logic       key_l;
        logic       printable;
        logic [1:0] term;
        logic [6:0] plain_ch;
        logic [6:0] caps_ch;
        logic [6:0] shift_ch;
        logic [7:0] limit;
    } cmd_t;

    typedef struct packed {
        action_t    action;
        logic [6:0] ch;
        logic [7:0] pos;
        logic [1:0] term;
        logic [7:0] len;
    } res_t;

    function automatic logic [6:0] plain_char(input logic [5:0] code);
        logic [6:0] c;
        case (code)
            6'd2:  c = 7'h31;
            6'd3:  c = 7'h32;
            6'd4:  c = 7'h33;
            6'd5:  c = 7'h34;
            6'd6:  c = 7'h35;
            6'd7:  c = 7'h36;
            6'd8:  c = 7'h37;
            6'd9:  c = 7'h38;
            6'd10: c = 7'h39;
            6'd11: c = 7'h30;
            6'd12: c = 7'h2d;
            6'd13: c = 7'h3d;
            6'd16: c = 7'h71;
            6'd17: c = 7'h77;
            6'd18: c = 7'h65;
            6'd19: c = 7'h72;
            6'd20: c = 7'h74;
            6'd21: c = 7'h79;
            6'd22: c = 7'h75;
            6'd23: c = 7'h69;
            6'd24: c = 7'h6f;
            6'd25: c = 7'h70;
            6'd26: c = 7'h5b;
            6'd27: c = 7'h5d;
            6'd30: c = 7'h61;
            6'd31: c = 7'h73;
            6'd32: c = 7'h64;
            6'd33: c = 7'h66;
            6'd34: c = 7'h67;
            6'd35: c = 7'h68;
            6'd36: c = 7'h6a;
            6'd37: c = 7'h6b;
            6'd38: c = 7'h6c;
            6'd39: c = 7'h3b;
            6'd40: c = 7'h27;
            6'd41: c = 7'h60;
            6'd43: c = 7'h5c;
            6'd44: c = 7'h7a;
            6'd45: c = 7'h78;
            6'd46: c = 7'h63;
            6'd47: c = 7'h76;
            6'd48: c = 7'h62;
            6'd49: c = 7'h6e;
            6'd50: c = 7'h6d;
            6'd51: c = 7'h2c;
            6'd52: c = 7'h2e;
            6'd53: c = 7'h2f;
            6'd57: c = 7'h20;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] shift_char(input logic [5:0] code);
        logic [6:0] c;
        case (code)
            6'd2:  c = 7'h21;
            6'd3:  c = 7'h40;
            6'd4:  c = 7'h23;
            6'd5:  c = 7'h24;
            6'd6:  c = 7'h25;
            6'd7:  c = 7'h5e;
            6'd8:  c = 7'h26;
            6'd9:  c = 7'h2a;
            6'd10: c = 7'h28;
            6'd11: c = 7'h29;
            6'd12: c = 7'h5f;
            6'd13: c = 7'h2b;
            6'd16: c = 7'h51;
            6'd17: c = 7'h57;
            6'd18: c = 7'h45;
            6'd19: c = 7'h52;
            6'd20: c = 7'h54;
            6'd21: c = 7'h59;
            6'd22: c = 7'h55;
            6'd23: c = 7'h49;
            6'd24: c = 7'h4f;
            6'd25: c = 7'h50;
            6'd26: c = 7'h7b;
            6'd27: c = 7'h7d;
            6'd30: c = 7'h41;
            6'd31: c = 7'h53;
            6'd32: c = 7'h44;
            6'd33: c = 7'h46;
            6'd34: c = 7'h47;
            6'd35: c = 7'h48;
            6'd36: c = 7'h4a;
            6'd37: c = 7'h4b;
            6'd38: c = 7'h4c;
            6'd39: c = 7'h3a;
            6'd40: c = 7'h22;
            6'd41: c = 7'h7e;
            6'd43: c = 7'h7c;
            6'd44: c = 7'h5a;
            6'd45: c = 7'h58;
            6'd46: c = 7'h43;
            6'd47: c = 7'h56;
            6'd48: c = 7'h42;
            6'd49: c = 7'h4e;
            6'd50: c = 7'h4d;
            6'd51: c = 7'h3c;
            6'd52: c = 7'h3e;
            6'd53: c = 7'h3f;
            6'd57: c = 7'h20;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

endpackage

[design/sce_front.sv]
// front end: classifies an incoming item and looks up its characters
// depends on sce_pkg
module sce_front (
    input  logic           kind,
    input  logic [7:0]     scan_code,
    input  logic [7:0]     max_chars,
    output sce_pkg::cmd_t  cmd
);
    import sce_pkg::*;

    logic [7:0] lim;
    logic [7:0] f_off;

    assign lim   = max_chars - 8'd1;
    assign f_off = scan_code - SC_F1;

    always_comb
    begin
        cmd           = '0;
        cmd.op        = OP_NONE;
        cmd.fkey      = (scan_code >= SC_F1) && (scan_code <= SC_F3);
        cmd.key_l     = (scan_code == SC_L);
        cmd.printable = (scan_code <= SC_F3);
        cmd.term      = f_off[1:0];
        cmd.plain_ch  = plain_char(scan_code[5:0]);
        cmd.shift_ch  = shift_char(scan_code[5:0]);
        cmd.caps_ch   = cmd.plain_ch;
        if (cmd.plain_ch inside {[7'h61:7'h7a]})
        begin
            cmd.caps_ch = cmd.plain_ch - 7'h20;
        end
        cmd.limit = (lim > LINE_LAST) ? LINE_LAST : lim;

        if (kind)
        begin
            cmd.op = (max_chars != 8'd0) ? OP_START : OP_NONE;
        end
        else
        begin
            case (scan_code)
                SC_CAPS:                  cmd.op = OP_CAPS;
                SC_LSHIFT_D, SC_RSHIFT_D: cmd.op = OP_SHIFT_D;
                SC_LSHIFT_U, SC_RSHIFT_U: cmd.op = OP_SHIFT_U;
                SC_CTRL_D:                cmd.op = OP_CTRL_D;
                SC_CTRL_U:                cmd.op = OP_CTRL_U;
                SC_ALT_D:                 cmd.op = OP_ALT_D;
                SC_ALT_U:                 cmd.op = OP_ALT_U;
                SC_ENTER:                 cmd.op = OP_ENTER;
                SC_BACKSPACE:             cmd.op = OP_BKSP;
                default:                  cmd.op = OP_KEY;
            endcase
        end
    end

endmodule

[design/sce_cmd_queue.sv]
// two-entry queue of classified commands between front and back
// depends on sce_pkg
module sce_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  sce_pkg::cmd_t  wr_cmd,
    output logic           full,
    input  logic           rd_en,
    output logic           rd_valid,
    output sce_pkg::cmd_t  rd_cmd
);
    import sce_pkg::*;

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_wr;
    logic       do_rd;

    assign full     = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_cmd   = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_wr && do_rd)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

[design/sce_back.sv]
// back end: keeps modifier and line state, executes commands, buffers results
// depends on sce_pkg
module sce_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  sce_pkg::cmd_t  cmd,
    output logic           cmd_take,
    output logic           res_empty,
    input  logic           res_pop,
    output sce_pkg::res_t  res
);
    import sce_pkg::*;

    logic       shift_reg, shift_next;
    logic       caps_reg, caps_next;
    logic       ctrl_reg, ctrl_next;
    logic       alt_reg, alt_next;
    logic       reading_reg, reading_next;
    logic [7:0] pos_reg, pos_next;
    logic [7:0] limit_reg, limit_next;
    res_t       r;

    res_t       buf_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_pop;

    assign cmd_take  = cmd_valid && (count_reg != 2'd2);
    assign res_empty = (count_reg == 2'd0);
    assign res       = buf_reg[rd_ptr_reg];
    assign do_pop    = res_pop && !res_empty;

    always_comb
    begin
        shift_next   = shift_reg;
        caps_next    = caps_reg;
        ctrl_next    = ctrl_reg;
        alt_next     = alt_reg;
        reading_next = reading_reg;
        pos_next     = pos_reg;
        limit_next   = limit_reg;
        r            = '0;
        r.action     = ACT_NONE;
        case (cmd.op)
            OP_START:
            begin
                limit_next   = cmd.limit;
                pos_next     = 8'd0;
                reading_next = 1'b1;
                shift_next   = 1'b0;
                caps_next    = 1'b0;
                ctrl_next    = 1'b0;
                r.action     = ACT_READ;
            end
            OP_CAPS:    caps_next  = !caps_reg;
            OP_SHIFT_D: shift_next = 1'b1;
            OP_SHIFT_U: shift_next = 1'b0;
            OP_CTRL_D:  ctrl_next  = 1'b1;
            OP_CTRL_U:  ctrl_next  = 1'b0;
            OP_ALT_D:   alt_next   = 1'b1;
            OP_ALT_U:   alt_next   = 1'b0;
            OP_ENTER, OP_BKSP, OP_KEY:
            begin
                if (alt_reg)
                begin
                    if (cmd.fkey)
                    begin
                        r.action = ACT_SWITCH;
                        r.term   = cmd.term;
                    end
                end
                else if (ctrl_reg)
                begin
                    if (cmd.key_l)
                    begin
                        r.action = ACT_CLEAR;
                    end
                end
                else if (reading_reg)
                begin
                    if (cmd.op == OP_ENTER)
                    begin
                        reading_next = 1'b0;
                        r.action     = ACT_DONE;
                        r.pos        = pos_reg;
                        r.len        = pos_reg;
                    end
                    else if (cmd.op == OP_BKSP)
                    begin
                        if (pos_reg != 8'd0)
                        begin
                            pos_next = pos_reg - 8'd1;
                            r.action = ACT_ERASE;
                            r.ch     = CH_SPACE;
                            r.pos    = pos_reg - 8'd1;
                        end
                    end
                    else if ((pos_reg < limit_reg) && cmd.printable)
                    begin
                        r.action = ACT_STORE;
                        r.ch     = shift_reg ? cmd.shift_ch
                                 : (caps_reg ? cmd.caps_ch : cmd.plain_ch);
                        r.pos    = pos_reg;
                        pos_next = pos_reg + 8'd1;
                    end
                end
            end
            default: r.action = ACT_NONE;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd_take && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!cmd_take && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg   <= 1'b0;
            caps_reg    <= 1'b0;
            ctrl_reg    <= 1'b0;
            alt_reg     <= 1'b0;
            reading_reg <= 1'b0;
            pos_reg     <= 8'd0;
            limit_reg   <= 8'd0;
            wr_ptr_reg  <= 1'b0;
            rd_ptr_reg  <= 1'b0;
            count_reg   <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (cmd_take)
            begin
                shift_reg   <= shift_next;
                caps_reg    <= caps_next;
                ctrl_reg    <= ctrl_next;
                alt_reg     <= alt_next;
                reading_reg <= reading_next;
                pos_reg     <= pos_next;
                limit_reg   <= limit_next;
                wr_ptr_reg  <= !wr_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            buf_reg[wr_ptr_reg] <= r;
        end
    end

endmodule

[design/scan_code_line_editor_core.sv]
// scan code line editor, top level
// an input is registered in the command queue, then executed and registered in the result queue
// throughput: one item per cycle while the result queue has room, set by the execute step in the back end
// front end classifies into a two-entry queue; back end feeds a two-entry result queue
// reset: asynchronous active low, clears all flags, line state and both queues
// depends on sce_pkg, sce_front, sce_cmd_queue, sce_back
module scan_code_line_editor_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic       kind,
    input  logic [7:0] scan_code,
    input  logic [7:0] max_chars,
    output logic       empty,
    input  logic       pop,
    output logic [2:0] action,
    output logic [6:0] char_out,
    output logic [7:0] position,
    output logic [1:0] terminal,
    output logic [7:0] line_length
);
    import sce_pkg::*;

    cmd_t front_cmd;
    cmd_t q_cmd;
    logic q_valid;
    logic q_take;
    res_t res;

    sce_front u_front (
        .kind      (kind),
        .scan_code (scan_code),
        .max_chars (max_chars),
        .cmd       (front_cmd)
    );

    sce_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_cmd   (front_cmd),
        .full     (full),
        .rd_en    (q_take),
        .rd_valid (q_valid),
        .rd_cmd   (q_cmd)
    );

    sce_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd       (q_cmd),
        .cmd_take  (q_take),
        .res_empty (empty),
        .res_pop   (pop),
        .res       (res)
    );

    assign action      = res.action;
    assign char_out    = res.ch;
    assign position    = res.pos;
    assign terminal    = res.term;
    assign line_length = res.len;

endmodule

[dv/tb_scan_code_line_editor_core.sv]
`timescale 1ns / 1ps
// testbench for scan_code_line_editor_core: directed and random scan code sessions
// a driver and a monitor around an in-bench line editor model, with random stalls on both queues
// depends on sce_pkg and scan_code_line_editor_core
module tb_scan_code_line_editor_core;
    import sce_pkg::*;

    localparam int RANDOM_ITEMS = 450;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic       kind_b;
        logic [7:0] code;
        logic [7:0] size;
    } key_item_t;

    typedef struct {
        action_t    act;
        logic [6:0] ch;
        logic [7:0] pos;
        logic [1:0] term;
        logic [7:0] len;
    } echo_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic       kind = 1'b0;
    logic [7:0] scan_code = 8'd0;
    logic [7:0] max_chars = 8'd0;
    logic       empty;
    logic       pop = 1'b0;
    logic [2:0] action;
    logic [6:0] char_out;
    logic [7:0] position;
    logic [1:0] terminal;
    logic [7:0] line_length;

    // plain and shifted characters by scan code, zero where no character exists
    logic [6:0] plain_keys [64] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2d, 7'h3d, 7'h00, 7'h00,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h00, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b,
        7'h27, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6e, 7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h00,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };
    logic [6:0] shift_keys [64] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e,
        7'h26, 7'h2a, 7'h28, 7'h29, 7'h5f, 7'h2b, 7'h00, 7'h00,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h00, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h3a,
        7'h22, 7'h7e, 7'h00, 7'h7c, 7'h5a, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4e, 7'h4d, 7'h3c, 7'h3e, 7'h3f, 7'h00, 7'h00,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    // editor state as the bench sees it
    bit         shift_on, caps_lock, ctrl_on, alt_on, line_open;
    logic [7:0] cursor, last_slot;

    key_item_t keystrokes [$];
    echo_t     expected_echo [$];
    key_item_t next_key;
    echo_t     want;

    bit  push_taken = 1'b0;
    bit  pop_taken = 1'b0;
    int  push_gap = 0;
    int  pop_wait = 0;
    int  keys_sent = 0;
    int  echoes_seen = 0;
    int  mismatches = 0;
    int  cycles = 0;
    int  action_count [8];

    scan_code_line_editor_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .scan_code   (scan_code),
        .max_chars   (max_chars),
        .empty       (empty),
        .pop         (pop),
        .action      (action),
        .char_out    (char_out),
        .position    (position),
        .terminal    (terminal),
        .line_length (line_length)
    );

    always #10 clk = ~clk;

    function automatic echo_t predict_edit(input logic k, input logic [7:0] code,
                                           input logic [7:0] size);
        echo_t      r;
        logic [7:0] lim;
        logic [6:0] c;
        r = '{act: ACT_NONE, ch: 7'd0, pos: 8'd0, term: 2'd0, len: 8'd0};
        if (k)
        begin
            if (size != 8'd0)
            begin
                lim = size - 8'd1;
                if (lim > LINE_LAST)
                    lim = LINE_LAST;
                last_slot = lim;
                cursor = 8'd0;
                line_open = 1'b1;
                shift_on = 1'b0;
                caps_lock = 1'b0;
                ctrl_on = 1'b0;
                r.act = ACT_READ;
            end
        end
        else if (code == SC_CAPS)
        begin
            caps_lock = !caps_lock;
        end
        else if (code == SC_LSHIFT_D || code == SC_RSHIFT_D)
        begin
            shift_on = 1'b1;
        end
        else if (code == SC_LSHIFT_U || code == SC_RSHIFT_U)
        begin
            shift_on = 1'b0;
        end
        else if (code == SC_CTRL_D)
        begin
            ctrl_on = 1'b1;
        end
        else if (code == SC_CTRL_U)
        begin
            ctrl_on = 1'b0;
        end
        else if (code == SC_ALT_D)
        begin
            alt_on = 1'b1;
        end
        else if (code == SC_ALT_U)
        begin
            alt_on = 1'b0;
        end
        else if (alt_on)
        begin
            if (code >= SC_F1 && code <= SC_F3)
            begin
                r.act = ACT_SWITCH;
                r.term = 2'(code - SC_F1);
            end
        end
        else if (ctrl_on)
        begin
            if (code == SC_L)
                r.act = ACT_CLEAR;
        end
        else if (line_open)
        begin
            if (code == SC_ENTER)
            begin
                line_open = 1'b0;
                r.act = ACT_DONE;
                r.pos = cursor;
                r.len = cursor;
            end
            else if (code == SC_BACKSPACE)
            begin
                if (cursor != 8'd0)
                begin
                    cursor = cursor - 8'd1;
                    r.act = ACT_ERASE;
                    r.ch = CH_SPACE;
                    r.pos = cursor;
                end
            end
            else if (cursor < last_slot && code <= SC_F3)
            begin
                c = shift_on ? shift_keys[code[5:0]] : plain_keys[code[5:0]];
                // caps lock only lifts a to z, and only without shift
                if (!shift_on && caps_lock && c >= 7'h61 && c <= 7'h7a)
                    c = c - 7'd32;
                r.act = ACT_STORE;
                r.ch = c;
                r.pos = cursor;
                cursor = cursor + 8'd1;
            end
        end
        return r;
    endfunction

    task automatic check_field(input string what, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
            mismatches++;
        end
    endtask

    task automatic add_item(input logic k, input logic [7:0] code, input logic [7:0] size);
        key_item_t it;
        it.kind_b = k;
        it.code = code;
        it.size = size;
        keystrokes.push_back(it);
    endtask

    task automatic add_key(input logic [7:0] code);
        add_item(1'b0, code, 8'($urandom_range(0, 255)));
    endtask

    // one keystroke or one ctrl or alt chord inside a line; typing_only leans hard toward characters
    task automatic add_line_key(input bit typing_only);
        int         r;
        logic [7:0] code;
        r = typing_only ? $urandom_range(0, 59) : $urandom_range(0, 99);
        if (r < 55)
        begin
            code = 8'($urandom_range(0, 8'h3d));
            // keep alt down, ctrl down and enter out of plain typing
            if (code == SC_ALT_D || code == SC_CTRL_D || code == SC_ENTER)
                code = 8'h1e;
            add_key(code);
        end
        else if (r < 65)
        begin
            add_key(SC_BACKSPACE);
        end
        else if (r < 72)
        begin
            case ($urandom_range(0, 3))
                0: add_key(SC_LSHIFT_D);
                1: add_key(SC_RSHIFT_D);
                2: add_key(SC_LSHIFT_U);
                default: add_key(SC_RSHIFT_U);
            endcase
        end
        else if (r < 77)
        begin
            add_key(SC_CAPS);
        end
        else if (r < 82)
        begin
            add_key(SC_CTRL_D);
            add_key($urandom_range(0, 1) ? SC_L : 8'($urandom_range(0, 255)));
            add_key(SC_CTRL_U);
        end
        else if (r < 87)
        begin
            add_key(SC_ALT_D);
            add_key($urandom_range(0, 3) != 0 ? 8'(SC_F1 + $urandom_range(0, 2))
                                              : 8'($urandom_range(0, 255)));
            add_key(SC_ALT_U);
        end
        else if (r < 95)
        begin
            add_key(8'($urandom_range(0, 8'h3d)) | 8'h80);
        end
        else
        begin
            add_key(8'($urandom_range(8'h3e, 8'hff)));
        end
    endtask

    task automatic add_line_session(input logic [7:0] size, input bit typing_only);
        int n;
        add_item(1'b1, 8'($urandom_range(0, 255)), size);
        if (size > 8'd64)
            n = int'(size > 8'd128 ? 8'd128 : size) + $urandom_range(0, 8);
        else
            n = $urandom_range(0, int'(size) + 3);
        repeat (n) add_line_key(typing_only);
        if ($urandom_range(0, 99) < 85)
            add_key(SC_ENTER);
    endtask

    task automatic add_noise();
        repeat ($urandom_range(1, 6))
            add_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) != 0)
        begin
            add_key(SC_ALT_U);
            add_key(SC_CTRL_U);
        end
    endtask

    task automatic build_stimulus();
        int         r;
        logic [7:0] size;
        int         goal;
        // idle editor, zero size, one-slot line that is full at once
        add_key(8'h1e);
        add_item(1'b1, 8'h00, 8'd0);
        add_item(1'b1, 8'h00, 8'd1);
        add_key(8'h1e);
        add_key(SC_BACKSPACE);
        add_key(SC_ENTER);
        // saturated size, caps and shift, zero entries, erase
        add_item(1'b1, 8'hff, 8'd255);
        add_key(8'h02);
        add_key(SC_CAPS);
        add_key(8'h1e);
        add_key(SC_LSHIFT_D);
        add_key(8'h1e);
        add_key(8'h0d);
        add_key(SC_LSHIFT_U);
        add_key(SC_RSHIFT_D);
        add_key(SC_F1);
        add_key(SC_BACKSPACE);
        // ctrl and alt combinations, ignored codes, restart while reading
        add_key(SC_CTRL_D);
        add_key(SC_L);
        add_key(SC_CTRL_U);
        add_key(SC_ALT_D);
        add_key(SC_F1);
        add_key(SC_F3);
        add_key(SC_ALT_U);
        add_key(8'h9e);
        add_item(1'b1, 8'h00, 8'd128);
        add_key(SC_ENTER);

        goal = keystrokes.size() + RANDOM_ITEMS;
        add_line_session(8'd255, 1'b1);
        while (keystrokes.size() < goal)
        begin
            r = $urandom_range(0, 99);
            if (r < 25)
            begin
                add_noise();
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    size = 8'd0;
                else if (r < 80)
                    size = 8'($urandom_range(1, 16));
                else if (r < 96)
                    size = 8'($urandom_range(17, 64));
                else
                    size = 8'($urandom_range(65, 255));
                add_line_session(size, r >= 96);
            end
        end
    endtask

    // input side driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (push && !push_taken)
            begin
            end
            else if (push_gap > 0)
            begin
                push <= 1'b0;
                push_gap = push_gap - 1;
                kind <= 1'($urandom_range(0, 1));
                scan_code <= 8'($urandom_range(0, 255));
                max_chars <= 8'($urandom_range(0, 255));
            end
            else if (keystrokes.size() != 0)
            begin
                next_key = keystrokes.pop_front();
                kind <= next_key.kind_b;
                scan_code <= next_key.code;
                max_chars <= next_key.size;
                push <= 1'b1;
                keys_sent++;
                push_gap = ((keys_sent / 40) % 4 == 3) ? 0 : $urandom_range(0, 7);
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // result side stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (pop_taken)
                pop_wait = ((echoes_seen / 40) % 4 == 1) ? 0 : $urandom_range(0, 7);
            if (pop_wait > 0)
            begin
                pop <= 1'b0;
                pop_wait = pop_wait - 1;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // monitor: predict on each input transfer, compare on each result transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            push_taken <= push && !full;
            pop_taken <= pop && !empty;
            if (push && !full)
                expected_echo.push_back(predict_edit(kind, scan_code, max_chars));
            if (pop && !empty)
            begin
                echoes_seen++;
                action_count[action]++;
                if (expected_echo.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual action %0d",
                             $time, action);
                    mismatches++;
                end
                else
                begin
                    want = expected_echo.pop_front();
                    check_field("action", 8'(want.act), 8'(action));
                    check_field("char_out", 8'(want.ch), 8'(char_out));
                    check_field("position", want.pos, position);
                    check_field("terminal", 8'(want.term), 8'(terminal));
                    check_field("line_length", want.len, line_length);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, expected_echo.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        build_stimulus();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        while (keystrokes.size() != 0 || push)
            @(posedge clk);
        while (expected_echo.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_echo.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_echo.size());
            mismatches++;
        end
        $display("run covered %0d scan code and start transfers, %0d results checked",
                 keys_sent, echoes_seen);
        $display("stored %0d, erased %0d, lines done %0d, switches %0d, clears %0d, starts %0d",
                 action_count[ACT_STORE], action_count[ACT_ERASE], action_count[ACT_DONE],
                 action_count[ACT_SWITCH], action_count[ACT_CLEAR], action_count[ACT_READ]);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
